/* hw/rtl/assert_macros.svh */
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on a named clock and active-low reset.
`define ATRK_ASSERT_CR(label, ck, rn, prop, msg) \
  label: assert property (@(posedge ck) disable iff (!rn) prop) \
    else $error(msg);

// Concurrent assertion on the block clock and reset.
`define ATRK_ASSERT(label, prop, msg) `ATRK_ASSERT_CR(label, clk, rst_n, prop, msg)

`endif

/* hw/rtl/atrk_pkg.sv */
`default_nettype none

package atrk_pkg;

  localparam int KIND_W = 2;
  localparam int ADDR_W = 32;
  localparam int SIZE_W = 31;
  localparam int LINE_W = 16;
  localparam int SUM_W  = 48;
  localparam int STAT_W = 2;

  // Request kind codes on the input port
  localparam logic [KIND_W-1:0] KIND_ALLOC  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_FREE   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_REPORT = 2'd2;

  localparam logic [SUM_W-1:0] SUM_MAX = '1;

  typedef enum logic [1:0] {
    OP_ALLOC,
    OP_FREE,
    OP_REPORT
  } op_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NULL      = 2'd2,
    ST_UNTRACKED = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_LOOKUP,
    BK_APPLY,
    BK_RPT_HEAD,
    BK_RPT_LIST
  } bk_state_t;

  // Classified request as it travels from front to back
  typedef struct packed {
    op_t               op;
    logic              addr_zero;
    logic [ADDR_W-1:0] addr;
    logic [SIZE_W-1:0] size;
    logic [LINE_W-1:0] line;
  } cmd_t;

endpackage

`default_nettype wire

/* hw/rtl/atrk_front.sv */
`default_nettype none

module atrk_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [atrk_pkg::KIND_W-1:0]   in_kind,
  input  logic [atrk_pkg::ADDR_W-1:0]   in_block_address,
  input  logic [atrk_pkg::SIZE_W-1:0]   in_alloc_size,
  input  logic [atrk_pkg::LINE_W-1:0]   in_source_line,
  input  logic                          q_full,
  output logic                          q_push,
  output atrk_pkg::cmd_t                q_din
);
  import atrk_pkg::*;

  logic cmd_vld_r, cmd_vld_nxt;
  cmd_t cmd_r, cmd_nxt;
  logic take;
  logic kind_ok;
  op_t  op_dec;

  // Decode the request kind; the spare code is dropped
  always_comb begin
    case (in_kind)
      KIND_ALLOC: begin
        op_dec  = OP_ALLOC;
        kind_ok = 1'b1;
      end
      KIND_FREE: begin
        op_dec  = OP_FREE;
        kind_ok = 1'b1;
      end
      KIND_REPORT: begin
        op_dec  = OP_REPORT;
        kind_ok = 1'b1;
      end
      default: begin
        op_dec  = OP_ALLOC;
        kind_ok = 1'b0;
      end
    endcase
  end

  // Hold one request; stall only while it cannot move into the queue
  assign busy   = cmd_vld_r && q_full;
  assign take   = start && !busy;
  assign q_push = cmd_vld_r && !q_full;
  assign q_din  = cmd_r;

  always_comb begin
    cmd_nxt = cmd_r;
    if (take) begin
      cmd_vld_nxt = kind_ok;
    end else if (q_push) begin
      cmd_vld_nxt = 1'b0;
    end else begin
      cmd_vld_nxt = cmd_vld_r;
    end
    if (take && kind_ok) begin
      cmd_nxt.op        = op_dec;
      cmd_nxt.addr_zero = (in_block_address == '0);
      cmd_nxt.addr      = in_block_address;
      cmd_nxt.size      = in_alloc_size;
      cmd_nxt.line      = in_source_line;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmd_vld_r <= 1'b0;
    end else begin
      cmd_vld_r <= cmd_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r <= cmd_nxt;
  end

endmodule

`default_nettype wire

/* hw/rtl/atrk_cmd_fifo.sv */
`default_nettype none

module atrk_cmd_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  atrk_pkg::cmd_t din,
  output logic           full,
  input  logic           pop,
  output atrk_pkg::cmd_t dout,
  output logic           empty
);
  import atrk_pkg::*;

  cmd_t       mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       do_push, do_pop;

  assign full    = (cnt_r == 2'd2);
  assign empty   = (cnt_r == 2'd0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem_r[rd_ptr_r];

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_nxt = do_push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Store the pushed request
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= din;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/atrk_back.sv */
`default_nettype none

module atrk_back #(
  parameter int TABLE_DEPTH = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          q_empty,
  input  atrk_pkg::cmd_t                q_dout,
  output logic                          q_pop,
  output logic                          out_valid,
  output logic [atrk_pkg::STAT_W-1:0]   out_status,
  output logic                          out_leak_detected,
  output logic [atrk_pkg::SUM_W-1:0]    out_allocated_total,
  output logic [atrk_pkg::SUM_W-1:0]    out_freed_total,
  output logic                          out_entry_valid,
  output logic [atrk_pkg::LINE_W-1:0]   out_leak_line,
  output logic                          out_last
);
  import atrk_pkg::*;

  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  // Slot table
  logic [ADDR_W-1:0] slot_addr_r [TABLE_DEPTH];
  logic [SIZE_W-1:0] slot_size_r [TABLE_DEPTH];
  logic [LINE_W-1:0] slot_line_r [TABLE_DEPTH];
  logic              slot_we;

  bk_state_t              state_r, state_nxt;
  cmd_t                   cur_r, cur_nxt;
  logic [TABLE_DEPTH-1:0] occ_r, occ_nxt;
  logic [TABLE_DEPTH-1:0] rem_r, rem_nxt;
  logic [SUM_W-1:0]       asum_r, asum_nxt;
  logic [SUM_W-1:0]       fsum_r, fsum_nxt;
  logic [IDX_W-1:0]       idx_r, idx_nxt;
  logic                   hit_r, hit_nxt;
  logic                   leak_r, leak_nxt;

  logic [TABLE_DEPTH-1:0] match;
  logic [IDX_W-1:0]       empty_idx, match_idx, pick_idx;
  logic                   leak_now;

  logic                   emit;
  status_t                e_status;
  logic                   e_leak, e_entry, e_last;
  logic [LINE_W-1:0]      e_line;

  logic                   out_valid_r;
  status_t                out_status_r;
  logic                   out_leak_r, out_entry_r, out_last_r;
  logic [SUM_W-1:0]       out_asum_r, out_fsum_r;
  logic [LINE_W-1:0]      out_line_r;

  function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] total,
                                               input logic [SIZE_W-1:0] amount);
    logic [SUM_W:0] s;
    s = {1'b0, total} + (SUM_W + 1)'(amount);
    return s[SUM_W] ? SUM_MAX : s[SUM_W-1:0];
  endfunction

  // Compare the request address against every occupied slot
  always_comb begin
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      match[i] = occ_r[i] && (slot_addr_r[i] == cur_r.addr);
    end
  end

  // Pick the lowest empty slot, lowest match and lowest remaining entry
  always_comb begin
    empty_idx = '0;
    match_idx = '0;
    pick_idx  = '0;
    for (int i = TABLE_DEPTH - 1; i >= 0; i--) begin
      if (!occ_r[i]) empty_idx = IDX_W'(i);
      if (match[i])  match_idx = IDX_W'(i);
      if (rem_r[i])  pick_idx  = IDX_W'(i);
    end
  end

  assign leak_now = (asum_r != fsum_r);

  // Sequence each request and form its results
  always_comb begin
    state_nxt = state_r;
    cur_nxt   = cur_r;
    occ_nxt   = occ_r;
    rem_nxt   = rem_r;
    asum_nxt  = asum_r;
    fsum_nxt  = fsum_r;
    idx_nxt   = idx_r;
    hit_nxt   = hit_r;
    leak_nxt  = leak_r;
    q_pop     = 1'b0;
    slot_we   = 1'b0;
    emit      = 1'b0;
    e_status  = ST_OK;
    e_leak    = 1'b0;
    e_entry   = 1'b0;
    e_line    = '0;
    e_last    = 1'b1;
    case (state_r)
      BK_IDLE: begin
        if (!q_empty) begin
          q_pop     = 1'b1;
          cur_nxt   = q_dout;
          state_nxt = (q_dout.op == OP_REPORT) ? BK_RPT_HEAD : BK_LOOKUP;
        end
      end
      BK_LOOKUP: begin
        if (cur_r.op == OP_ALLOC) begin
          hit_nxt = |(~occ_r);
          idx_nxt = empty_idx;
        end else begin
          hit_nxt = !cur_r.addr_zero && (|match);
          idx_nxt = match_idx;
        end
        state_nxt = BK_APPLY;
      end
      BK_APPLY: begin
        emit = 1'b1;
        if (cur_r.op == OP_ALLOC) begin
          if (hit_r) begin
            slot_we = 1'b1;
            if (!cur_r.addr_zero) begin
              occ_nxt[idx_r] = 1'b1;
            end
            asum_nxt = sat_add(asum_r, cur_r.size);
          end else begin
            e_status = ST_FULL;
          end
        end else if (cur_r.addr_zero) begin
          e_status = ST_NULL;
        end else if (hit_r) begin
          fsum_nxt       = sat_add(fsum_r, slot_size_r[idx_r]);
          occ_nxt[idx_r] = 1'b0;
        end else begin
          e_status = ST_UNTRACKED;
        end
        state_nxt = BK_IDLE;
      end
      BK_RPT_HEAD: begin
        emit      = 1'b1;
        e_leak    = leak_now;
        leak_nxt  = leak_now;
        rem_nxt   = leak_now ? occ_r : '0;
        e_last    = (rem_nxt == '0);
        state_nxt = e_last ? BK_IDLE : BK_RPT_LIST;
      end
      BK_RPT_LIST: begin
        emit    = 1'b1;
        e_leak  = leak_r;
        e_entry = 1'b1;
        e_line  = slot_line_r[pick_idx];
        rem_nxt = rem_r & (rem_r - 1'b1);
        e_last  = (rem_nxt == '0);
        if (e_last) begin
          state_nxt = BK_IDLE;
        end
      end
      default: begin
        state_nxt = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BK_IDLE;
      occ_r   <= '0;
      rem_r   <= '0;
      asum_r  <= '0;
      fsum_r  <= '0;
    end else begin
      state_r <= state_nxt;
      occ_r   <= occ_nxt;
      rem_r   <= rem_nxt;
      asum_r  <= asum_nxt;
      fsum_r  <= fsum_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r  <= cur_nxt;
    idx_r  <= idx_nxt;
    hit_r  <= hit_nxt;
    leak_r <= leak_nxt;
  end

  // Record an allocation in its slot
  always_ff @(posedge clk) begin
    if (slot_we) begin
      slot_addr_r[idx_r] <= cur_r.addr;
      slot_size_r[idx_r] <= cur_r.size;
      slot_line_r[idx_r] <= cur_r.line;
    end
  end

  // Register the result strobe and fields
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_status_r <= e_status;
      out_leak_r   <= e_leak;
      out_asum_r   <= asum_nxt;
      out_fsum_r   <= fsum_nxt;
      out_entry_r  <= e_entry;
      out_line_r   <= e_line;
      out_last_r   <= e_last;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_status          = out_status_r;
  assign out_leak_detected   = out_leak_r;
  assign out_allocated_total = out_asum_r;
  assign out_freed_total     = out_fsum_r;
  assign out_entry_valid     = out_entry_r;
  assign out_leak_line       = out_line_r;
  assign out_last            = out_last_r;

endmodule

`default_nettype wire

/* hw/rtl/allocation_tracking_table.sv */
`default_nettype none

// Allocation tracking table. A request is taken on a clock edge with start high and busy
// low; the front stage classifies it and hands it through a two-entry queue to the
// executing back end, so busy rises only when the front register and the queue are both
// full. Allocate and free pass through dequeue, parallel slot match and update in the
// back end and yield one result; report passes through dequeue and a head result, then
// lists one result for each occupied slot, so it yields 1 + n results on consecutive
// cycles, n being the occupied slots when the totals differ. Each result shows on the
// out_ ports for exactly one cycle with out_valid high and cannot be held off, so the
// receiver must take it on that edge. out_last marks the final result of each request.
// Reset empties the table and clears both totals at once.
module allocation_tracking_table #(
  parameter int TABLE_DEPTH = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [atrk_pkg::KIND_W-1:0]   in_kind,
  input  logic [atrk_pkg::ADDR_W-1:0]   in_block_address,
  input  logic [atrk_pkg::SIZE_W-1:0]   in_alloc_size,
  input  logic [atrk_pkg::LINE_W-1:0]   in_source_line,
  output logic                          out_valid,
  output logic [atrk_pkg::STAT_W-1:0]   out_status,
  output logic                          out_leak_detected,
  output logic [atrk_pkg::SUM_W-1:0]    out_allocated_total,
  output logic [atrk_pkg::SUM_W-1:0]    out_freed_total,
  output logic                          out_entry_valid,
  output logic [atrk_pkg::LINE_W-1:0]   out_leak_line,
  output logic                          out_last
);
  import atrk_pkg::*;

  logic q_push, q_full, q_pop, q_empty;
  cmd_t q_din, q_dout;

  // Accept and classify requests
  atrk_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_kind          (in_kind),
    .in_block_address (in_block_address),
    .in_alloc_size    (in_alloc_size),
    .in_source_line   (in_source_line),
    .q_full           (q_full),
    .q_push           (q_push),
    .q_din            (q_din)
  );

  // Decouple front and back
  atrk_cmd_fifo u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .din   (q_din),
    .full  (q_full),
    .pop   (q_pop),
    .dout  (q_dout),
    .empty (q_empty)
  );

  // Execute requests against the table
  atrk_back #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .q_empty             (q_empty),
    .q_dout              (q_dout),
    .q_pop               (q_pop),
    .out_valid           (out_valid),
    .out_status          (out_status),
    .out_leak_detected   (out_leak_detected),
    .out_allocated_total (out_allocated_total),
    .out_freed_total     (out_freed_total),
    .out_entry_valid     (out_entry_valid),
    .out_leak_line       (out_leak_line),
    .out_last            (out_last)
  );

endmodule

`default_nettype wire

/* hw/rtl/atrk_checker.sv */
`default_nettype none

`include "assert_macros.svh"

module atrk_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic                          busy,
  input  logic [atrk_pkg::KIND_W-1:0]   in_kind,
  input  logic [atrk_pkg::ADDR_W-1:0]   in_block_address,
  input  logic [atrk_pkg::SIZE_W-1:0]   in_alloc_size,
  input  logic [atrk_pkg::LINE_W-1:0]   in_source_line,
  input  logic                          out_valid,
  input  logic [atrk_pkg::STAT_W-1:0]   out_status,
  input  logic                          out_leak_detected,
  input  logic [atrk_pkg::SUM_W-1:0]    out_allocated_total,
  input  logic [atrk_pkg::SUM_W-1:0]    out_freed_total,
  input  logic                          out_entry_valid,
  input  logic [atrk_pkg::LINE_W-1:0]   out_leak_line,
  input  logic                          out_last
);

  // A listed entry only appears inside a leak report
  `ATRK_ASSERT(a_entry_has_leak, out_valid && out_entry_valid |-> out_leak_detected, "entry without leak flag")

  // A listed entry follows directly on an unfinished report result
  `ATRK_ASSERT(a_entry_follows, out_valid && out_entry_valid |-> $past(out_valid) && !$past(out_last), "entry not preceded by open report")

  // An unfinished request continues with a listed entry on the next cycle
  `ATRK_ASSERT(a_burst_continues, out_valid && !out_last |=> out_valid && out_entry_valid, "report burst broken")

  // Totals hold steady across a report burst
  `ATRK_ASSERT(a_totals_steady, out_valid && out_entry_valid |-> $stable(out_allocated_total) && $stable(out_freed_total), "totals moved inside report")

endmodule

bind allocation_tracking_table atrk_checker u_atrk_checker (.*);

`default_nettype wire
